// ===== rtl/assert_macros.svh =====
// Assertion macros used by the sequencer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, switched off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose property is checked in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/vfhs_pkg.sv =====
`default_nettype none

package vfhs_pkg;

  // Feeder sequencer modes.
  typedef enum logic [2:0] {
    FeedStart  = 3'd0,
    FeedRamp   = 3'd1,
    FeedMoving = 3'd2,
    FeedPaused = 3'd3,
    FeedShort  = 3'd4
  } feeder_state_e;

  // Hopper sequencer modes.
  typedef enum logic [1:0] {
    HopDown       = 2'd0,
    HopWaitBottom = 2'd1,
    HopUp         = 2'd2,
    HopWaitTop    = 2'd3
  } hopper_state_e;

  // Stepper commands reported with each result word.
  typedef enum logic [1:0] {
    StepNone     = 2'd0,
    StepMove     = 2'd1,
    StepStop     = 2'd2,
    StepStopZero = 2'd3
  } stepper_cmd_e;

  // Commands carried by an input word; the spare code acts as a tick.
  typedef enum logic [1:0] {
    CmdTick        = 2'd0,
    CmdHopperStart = 2'd1,
    CmdHopperStop  = 2'd2
  } host_cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegCycleInterval = 3'd0,
    RegVibrationPwm  = 3'd1,
    RegPause         = 3'd2,
    RegShortMove     = 3'd3,
    RegLongMove      = 3'd4,
    RegStrokeSteps   = 3'd5
  } cfg_reg_e;

  localparam logic [15:0] PartLimit    = 16'd20;
  localparam logic [31:0] RampMs       = 32'd1000;
  localparam logic [7:0]  RampBase     = 8'd60;
  localparam logic [31:0] BottomWaitMs = 32'd10;
  localparam logic [16:0] Overtravel   = 17'd20;

  // Reciprocal of the ramp length: floor(x / 1000) == (x * RampRecip) >> RampShift
  // holds exactly for every x below 493447.
  localparam logic [18:0] RampRecip = 19'd268436;
  localparam int          RampShift = 28;

  // Register reset values.
  localparam logic [14:0] CycleIntervalRst = 15'd12000;
  localparam logic [7:0]  VibrationPwmRst  = 8'd92;
  localparam logic [14:0] PauseRst         = 15'd1000;
  localparam logic [14:0] ShortMoveRst     = 15'd60;
  localparam logic [14:0] LongMoveRst      = 15'd3000;
  localparam logic [14:0] StrokeStepsRst   = 15'd2020;
  // |92 - 60| * RampRecip, the ramp slope that belongs to the reset duty.
  localparam logic [25:0] RampSlopeRst     = 26'd8589952;

endpackage

`default_nettype wire

// ===== rtl/vibratory_feeder_hopper_sequencer_core.sv =====
// Vibratory feeder and hopper sequencer.
//
// The input channel (in_valid_i / in_stall_o) carries one word per tick or
// command: command, millisecond time, distance, bottom switch and stepper
// busy. The output channel (out_valid_o / out_stall_i) returns one result
// word per input word: feeder drive, stepper command and step count, both
// modes and the accumulated vibration time.
// The result of an accepted word is registered and valid in the cycle after
// it is accepted. Throughput is one word per cycle unless out_stall_i holds
// a pending result; the whole step, including the ramp duty product against
// a slope that is prescaled when the duty register is written, sits between
// the input ports and the state and result registers.
// While a result waits under out_stall_i, the block raises in_stall_o and
// holds its state, so the result stays unchanged until it is taken; a word
// can be accepted in the same cycle in which the pending result is taken.
// Reset loads the register defaults, puts the feeder in start mode and the
// hopper in waiting top, clears all times and drops any pending result.
// The APB port takes writes in its access cycle, pready is always high and
// reads return the stored register values.
`default_nettype none

`include "assert_macros.svh"

module vibratory_feeder_hopper_sequencer_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input channel.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [31:0]         now_ms_i,
  input  wire logic [15:0]         distance_i,
  input  wire logic                limit_switch_i,
  input  wire logic                stepper_busy_i,
  // Output channel.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     drive_enable_o,
  output logic [7:0]               drive_duty_o,
  output logic [1:0]               stepper_cmd_o,
  output logic signed [16:0]       move_steps_o,
  output logic [2:0]               feeder_mode_o,
  output logic [1:0]               hopper_mode_o,
  output logic [31:0]              vibration_total_ms_o,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import vfhs_pkg::*;

  // Configuration registers.
  logic [14:0] cycle_interval_q;
  logic [7:0]  vibration_pwm_q;
  logic [14:0] pause_q;
  logic [14:0] short_move_q;
  logic [14:0] long_move_q;
  logic [14:0] stroke_steps_q;
  logic [25:0] ramp_slope_q, ramp_slope_d;
  logic        ramp_neg_q, ramp_neg_d;

  // Sequencer state.
  feeder_state_e feeder_q, feeder_d;
  hopper_state_e hopper_q, hopper_d;
  logic [31:0]   total_q, total_d;
  logic [31:0]   feed_time_q, feed_time_d;
  logic [31:0]   vib_start_q, vib_start_d;
  logic [31:0]   hop_time_q, hop_time_d;
  logic          motor_on_q, motor_on_d;
  logic [7:0]    motor_duty_q, motor_duty_d;

  // Result register for the parts that are not state.
  stepper_cmd_e       step_cmd_q, step_cmd_d;
  logic signed [16:0] move_steps_q, move_steps_d;
  logic               out_valid_q, out_valid_d;

  logic        in_accept;
  logic        cfg_write;
  logic [2:0]  cfg_index;

  // APB access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_comb begin
    case (cfg_index)
      RegCycleInterval: prdata = {17'd0, cycle_interval_q};
      RegVibrationPwm:  prdata = {24'd0, vibration_pwm_q};
      RegPause:         prdata = {17'd0, pause_q};
      RegShortMove:     prdata = {17'd0, short_move_q};
      RegLongMove:      prdata = {17'd0, long_move_q};
      RegStrokeSteps:   prdata = {17'd0, stroke_steps_q};
      default:          prdata = 32'd0;
    endcase
  end

  // The ramp slope |duty - 60| is prescaled by the reciprocal of 1000 at write time.
  logic signed [8:0] duty_delta;
  logic [7:0]        duty_mag;
  logic [26:0]       slope_full;

  assign duty_delta   = $signed({1'b0, pwdata[7:0]}) - $signed({1'b0, RampBase});
  assign duty_mag     = duty_delta[8] ? 8'(-duty_delta) : duty_delta[7:0];
  assign slope_full   = duty_mag * RampRecip;
  assign ramp_slope_d = slope_full[25:0];
  assign ramp_neg_d   = duty_delta[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_interval_q <= CycleIntervalRst;
      vibration_pwm_q  <= VibrationPwmRst;
      pause_q          <= PauseRst;
      short_move_q     <= ShortMoveRst;
      long_move_q      <= LongMoveRst;
      stroke_steps_q   <= StrokeStepsRst;
      ramp_slope_q     <= RampSlopeRst;
      ramp_neg_q       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegCycleInterval: cycle_interval_q <= pwdata[14:0];
        RegVibrationPwm: begin
          vibration_pwm_q <= pwdata[7:0];
          ramp_slope_q    <= ramp_slope_d;
          ramp_neg_q      <= ramp_neg_d;
        end
        RegPause:       pause_q        <= pwdata[14:0];
        RegShortMove:   short_move_q   <= pwdata[14:0];
        RegLongMove:    long_move_q    <= pwdata[14:0];
        RegStrokeSteps: stroke_steps_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Handshake: the state doubles as the result, so it holds while a result waits.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_d = in_accept || (out_valid_q && out_stall_i);

  // Feeder conditions.
  logic        part;
  logic [31:0] move_el;
  logic [31:0] feed_el;
  logic        move_stop;
  logic        in_ramp;
  logic        pause_done;
  logic        short_end;
  logic        feed_finish;
  logic [31:0] finish_el;
  logic [31:0] total_feed;

  assign part        = distance_i < PartLimit;
  assign move_el     = now_ms_i - vib_start_q;
  assign feed_el     = now_ms_i - feed_time_q;
  assign move_stop   = part || (move_el >= {17'd0, long_move_q});
  assign in_ramp     = move_el < RampMs;
  assign pause_done  = feed_el >= {17'd0, pause_q};
  assign short_end   = (feed_el >= {17'd0, short_move_q}) || !part;
  assign feed_finish = (((feeder_q == FeedRamp) || (feeder_q == FeedMoving)) && move_stop)
                    || ((feeder_q == FeedShort) && short_end);
  assign finish_el   = (feeder_q == FeedShort) ? feed_el : move_el;
  assign total_feed  = total_q + (feed_finish ? finish_el : 32'd0);

  // Ramp duty: 60 +/- floor(elapsed * |delta| / 1000), truncated toward zero.
  logic [35:0] ramp_prod;
  logic [7:0]  ramp_step;
  logic [7:0]  ramp_duty;

  assign ramp_prod = move_el[9:0] * ramp_slope_q;
  assign ramp_step = ramp_prod[RampShift +: 8];
  assign ramp_duty = ramp_neg_q ? RampBase - ramp_step : RampBase + ramp_step;

  // Feeder next state.
  always_comb begin
    feeder_d = feeder_q;
    case (feeder_q)
      FeedRamp: begin
        if (move_stop) begin
          feeder_d = FeedPaused;
        end else if (!in_ramp) begin
          feeder_d = FeedMoving;
        end
      end
      FeedMoving: begin
        if (move_stop) begin
          feeder_d = FeedPaused;
        end
      end
      FeedPaused: begin
        if (pause_done) begin
          feeder_d = part ? FeedShort : FeedStart;
        end
      end
      FeedShort: begin
        if (short_end) begin
          feeder_d = FeedPaused;
        end
      end
      default: feeder_d = FeedRamp;
    endcase
  end

  // Feeder drive and timestamps.
  always_comb begin
    motor_on_d   = motor_on_q;
    motor_duty_d = motor_duty_q;
    vib_start_d  = vib_start_q;
    feed_time_d  = feed_time_q;
    case (feeder_q)
      FeedRamp, FeedMoving, FeedShort: begin
        if (feed_finish) begin
          motor_on_d   = 1'b0;
          motor_duty_d = 8'd0;
          feed_time_d  = now_ms_i;
        end else if (feeder_q == FeedRamp) begin
          motor_on_d   = 1'b1;
          motor_duty_d = in_ramp ? ramp_duty : vibration_pwm_q;
        end
      end
      FeedPaused: begin
        if (pause_done && part) begin
          motor_on_d   = 1'b1;
          motor_duty_d = vibration_pwm_q;
          vib_start_d  = now_ms_i;
          feed_time_d  = now_ms_i;
        end
      end
      default: vib_start_d = now_ms_i;
    endcase
  end

  // Hopper conditions after the host command.
  hopper_state_e      hop_cmd;
  logic               busy_eff;
  logic               at_bottom;
  logic               hop_trigger;
  logic               hop_at_end;
  logic               hop_wait_done;
  logic [16:0]        stroke_ext;
  logic signed [16:0] down_steps;
  logic signed [16:0] up_steps;

  assign at_bottom     = !limit_switch_i;
  assign busy_eff      = stepper_busy_i || (cmd_i == CmdHopperStart);
  assign hop_trigger   = total_feed >= {17'd0, cycle_interval_q};
  assign hop_at_end    = at_bottom || !busy_eff;
  assign hop_wait_done = (now_ms_i - hop_time_q) >= BottomWaitMs;
  assign stroke_ext    = {2'b00, stroke_steps_q};
  assign down_steps    = $signed(17'd0 - (stroke_ext + Overtravel));
  assign up_steps      = $signed(stroke_ext);

  always_comb begin
    case (cmd_i)
      CmdHopperStart: hop_cmd = HopDown;
      CmdHopperStop:  hop_cmd = HopWaitTop;
      default:        hop_cmd = hopper_q;
    endcase
  end

  // Hopper next state.
  always_comb begin
    hopper_d = hop_cmd;
    case (hop_cmd)
      HopWaitTop: begin
        if (hop_trigger) begin
          hopper_d = HopDown;
        end
      end
      HopDown: begin
        if (hop_at_end) begin
          hopper_d = HopWaitBottom;
        end
      end
      HopWaitBottom: begin
        if (hop_wait_done) begin
          hopper_d = HopUp;
        end
      end
      default: begin
        if (!busy_eff) begin
          hopper_d = HopWaitTop;
        end
      end
    endcase
  end

  // Stepper command, hopper timestamp and accumulator; a hopper command overrides the host one.
  always_comb begin
    hop_time_d = hop_time_q;
    total_d    = total_feed;
    case (cmd_i)
      CmdHopperStart: begin
        step_cmd_d   = StepMove;
        move_steps_d = down_steps;
      end
      CmdHopperStop: begin
        step_cmd_d   = StepStop;
        move_steps_d = '0;
      end
      default: begin
        step_cmd_d   = StepNone;
        move_steps_d = '0;
      end
    endcase
    case (hop_cmd)
      HopWaitTop: begin
        if (hop_trigger) begin
          total_d      = 32'd0;
          step_cmd_d   = StepMove;
          move_steps_d = down_steps;
        end
      end
      HopDown: begin
        if (hop_at_end) begin
          step_cmd_d   = StepStopZero;
          move_steps_d = '0;
          hop_time_d   = now_ms_i;
        end
      end
      HopWaitBottom: begin
        if (hop_wait_done) begin
          step_cmd_d   = StepMove;
          move_steps_d = up_steps;
        end
      end
      default: ;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feeder_q     <= FeedStart;
      hopper_q     <= HopWaitTop;
      total_q      <= 32'd0;
      feed_time_q  <= 32'd0;
      vib_start_q  <= 32'd0;
      hop_time_q   <= 32'd0;
      motor_on_q   <= 1'b0;
      motor_duty_q <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        feeder_q     <= feeder_d;
        hopper_q     <= hopper_d;
        total_q      <= total_d;
        feed_time_q  <= feed_time_d;
        vib_start_q  <= vib_start_d;
        hop_time_q   <= hop_time_d;
        motor_on_q   <= motor_on_d;
        motor_duty_q <= motor_duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      step_cmd_q   <= step_cmd_d;
      move_steps_q <= move_steps_d;
    end
  end

  // Result word.
  assign out_valid_o          = out_valid_q;
  assign drive_enable_o       = motor_on_q;
  assign drive_duty_o         = motor_duty_q;
  assign stepper_cmd_o        = step_cmd_q;
  assign move_steps_o         = move_steps_q;
  assign feeder_mode_o        = feeder_q;
  assign hopper_mode_o        = hopper_q;
  assign vibration_total_ms_o = total_q;

  // Checks.
  `ASSERT_CLK(a_steps_only_on_move,
              !out_valid_o || (stepper_cmd_o == StepMove) || (move_steps_o == 17'sd0),
              "step count reported without a move command")
  `ASSERT_CLK(a_off_means_zero_duty, drive_enable_o || (drive_duty_o == 8'd0),
              "feeder drive off with a nonzero duty")
  `ASSERT_CLK(a_idle_feeder_motor_off,
              !((feeder_q == FeedPaused) || (feeder_q == FeedStart)) || !motor_on_q,
              "feeder motor on while paused or in start mode")
  `ASSERT_NEXT(a_start_goes_down, in_accept && (cmd_i == CmdHopperStart),
               (hopper_q == HopDown) || (hopper_q == HopWaitBottom),
               "hopper start command did not send the hopper down")

endmodule

`default_nettype wire
